// ----- hw/rtl/whll_pkg.sv -----
package whll_pkg;

    localparam int PRICE_W    = 32;
    localparam int WLEN_W     = 6;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd5;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 136;

    typedef enum logic [2:0] {
        TREND_NEUTRAL     = 3'd0,
        TREND_UP          = 3'd1,
        TREND_DOWN        = 3'd2,
        TREND_EXPANDING   = 3'd3,
        TREND_CONTRACTING = 3'd4
    } trend_t;

    typedef struct packed {
        logic [PRICE_W-1:0] higher_high_amount;
        logic [PRICE_W-1:0] lower_low_amount;
        logic [PRICE_W-1:0] higher_low_amount;
        logic [PRICE_W-1:0] lower_high_amount;
        trend_t             trend_code;
    } res_t;

endpackage

// ----- hw/rtl/window_high_low_structure_core.sv -----
// Higher-highs / lower-lows structure detector.
// Slave stream: one word per bar, tdata = {low_price, high_price}.
// Master stream: one word per bar once 2P bars are held (P = effective
// window length), carrying the clipped differences between the max high
// and min low of the older and newer P-bar windows, plus a trend code.
// Bars accepted before the history is full give no output word.
// cfg_we/cfg_wdata write window_length (0 acts as 1, above MAX_WINDOW
// saturates); a write restarts the 2P-bar fill. Write only while idle.
// Flow: a bar that gives no output leaves s_tready high, so such bars can
// follow back to back. A bar that gives output starts a scan: the history
// RAM is read one entry per cycle over all 2P held bars through a single
// max/min compare, then one shared subtractor forms the four differences,
// first for the highs and then for the lows, and the trend code is set.
// s_tready stays low during that time. The result waits in the scanner
// and the output register while m_tready is low; the next bar is taken
// once the scanner has handed its result over. Reset clears the fill
// count, write pointer and valid flags; window_length returns to 5.
module window_high_low_structure_core
    import whll_pkg::*;
#(
    parameter int MAX_WINDOW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [WLEN_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // high_price, low_price
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // higher_high_amount, lower_low_amount, higher_low_amount,
    // lower_high_amount, trend_code, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int DEPTH = 2 * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(MAX_WINDOW + 1);

    logic [WLEN_W-1:0] wlen_reg;
    logic [AW-1:0]     write_slot_reg, write_slot_next;
    logic [PW:0]       fill_reg, fill_next;
    logic              start_reg;
    logic [PW-1:0]     p;
    logic [PW:0]       need;
    logic              in_take;

    logic              scan_idle;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [2*PRICE_W-1:0] rd_data;
    logic              res_valid;
    logic              res_take;
    res_t              res;

    logic              out_valid_reg;
    res_t              out_reg;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            p = PW'(1);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            p = PW'(MAX_WINDOW);
        end
        else
        begin
            p = PW'(wlen_reg);
        end
    end

    assign need     = {p, 1'b0};
    assign s_tready = scan_idle && !start_reg;
    assign in_take  = s_tvalid && s_tready;

    assign write_slot_next = (write_slot_reg == AW'(DEPTH - 1)) ? '0 : write_slot_reg + 1'b1;

    always_comb
    begin
        fill_next = fill_reg;
        if (fill_reg < need)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (fill_reg > need)
        begin
            fill_next = need;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg       <= WLEN_RESET;
            write_slot_reg <= '0;
            fill_reg       <= '0;
            start_reg      <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_we)
            begin
                wlen_reg <= cfg_wdata;
                fill_reg <= '0;
            end
            else if (in_take)
            begin
                write_slot_reg <= write_slot_next;
                fill_reg       <= fill_next;
                start_reg      <= (fill_next == need);
            end
        end
    end

    whll_hist_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (2 * PRICE_W)
    ) u_hist (
        .clk   (clk),
        .we    (in_take),
        .waddr (write_slot_reg),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    whll_scan #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .PW    (PW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .write_slot (write_slot_reg),
        .p          (p),
        .idle       (scan_idle),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_reg.trend_code,
                       out_reg.lower_high_amount,
                       out_reg.higher_low_amount,
                       out_reg.lower_low_amount,
                       out_reg.higher_high_amount};

endmodule

// ----- hw/rtl/whll_hist_ram.sv -----
module whll_hist_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/whll_scan.sv -----
module whll_scan
    import whll_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int PW    = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AW-1:0]        write_slot,
    input  logic [PW-1:0]        p,
    output logic                 idle,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  logic [2*PRICE_W-1:0] rd_data,
    output logic                 res_valid,
    input  logic                 res_take,
    output res_t                 res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIFF_HI,
        ST_DIFF_LO,
        ST_CODE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [PW:0]        need;
    logic [PW:0]        cnt_reg, cnt_next;
    logic [PW:0]        idx_reg;
    logic               dv_reg;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW:0]        need_ext;
    logic [AW:0]        ws_ext;
    logic [AW-1:0]      start_addr;

    logic [PRICE_W-1:0] acc_hi_reg, acc_lo_reg;
    logic [PRICE_W-1:0] old_hi_reg, old_lo_reg;
    logic [PRICE_W-1:0] d_hi, d_lo, comb_hi, comb_lo;
    logic               first_of_window;

    logic [PRICE_W-1:0] op_a, op_b, big, sml, diff;
    logic               a_gt_b;

    res_t               res_reg;

    assign need     = {p, 1'b0};
    assign need_ext = (AW+1)'(need);
    assign ws_ext   = {1'b0, write_slot};

    always_comb
    begin
        if (ws_ext >= need_ext)
        begin
            start_addr = AW'(ws_ext - need_ext);
        end
        else
        begin
            start_addr = AW'(ws_ext + (AW+1)'(DEPTH) - need_ext);
        end
    end

    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg < need);
    assign rd_addr = addr_reg;

    assign d_hi = rd_data[PRICE_W-1:0];
    assign d_lo = rd_data[2*PRICE_W-1:PRICE_W];
    assign first_of_window = (idx_reg == '0) || (idx_reg == (PW+1)'(p));
    assign comb_hi = (first_of_window || (d_hi > acc_hi_reg)) ? d_hi : acc_hi_reg;
    assign comb_lo = (first_of_window || (d_lo < acc_lo_reg)) ? d_lo : acc_lo_reg;

    // shared compare/subtract: |a - b| and which side is larger
    always_comb
    begin
        if (state_reg == ST_DIFF_HI)
        begin
            op_a = acc_hi_reg;
            op_b = old_hi_reg;
        end
        else
        begin
            op_a = acc_lo_reg;
            op_b = old_lo_reg;
        end
    end

    assign a_gt_b = op_a > op_b;
    assign big    = a_gt_b ? op_a : op_b;
    assign sml    = a_gt_b ? op_b : op_a;
    assign diff   = big - sml;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    addr_next  = start_addr;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    addr_next = (addr_reg == AW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
                end
                if (dv_reg && (idx_reg == need - 1'b1))
                begin
                    state_next = ST_DIFF_HI;
                end
            end
            ST_DIFF_HI: state_next = ST_DIFF_LO;
            ST_DIFF_LO: state_next = ST_CODE;
            ST_CODE:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dv_reg    <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        idx_reg  <= cnt_reg;
        if (dv_reg)
        begin
            acc_hi_reg <= comb_hi;
            acc_lo_reg <= comb_lo;
            if (idx_reg == (PW+1)'(p) - 1'b1)
            begin
                old_hi_reg <= comb_hi;
                old_lo_reg <= comb_lo;
            end
        end
        unique case (state_reg)
            ST_DIFF_HI:
            begin
                res_reg.higher_high_amount <= a_gt_b ? diff : '0;
                res_reg.lower_high_amount  <= a_gt_b ? '0 : diff;
            end
            ST_DIFF_LO:
            begin
                res_reg.higher_low_amount <= a_gt_b ? diff : '0;
                res_reg.lower_low_amount  <= a_gt_b ? '0 : diff;
            end
            ST_CODE:
            begin
                priority if ((res_reg.higher_high_amount != '0) &&
                             (res_reg.higher_low_amount != '0))
                    res_reg.trend_code <= TREND_UP;
                else if ((res_reg.lower_high_amount != '0) &&
                         (res_reg.lower_low_amount != '0))
                    res_reg.trend_code <= TREND_DOWN;
                else if ((res_reg.higher_high_amount != '0) &&
                         (res_reg.lower_low_amount != '0))
                    res_reg.trend_code <= TREND_EXPANDING;
                else if ((res_reg.lower_high_amount != '0) &&
                         (res_reg.higher_low_amount != '0))
                    res_reg.trend_code <= TREND_CONTRACTING;
                else
                    res_reg.trend_code <= TREND_NEUTRAL;
            end
            default:
            begin
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule
